[design/cslx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslx_pkg
// Shared types and constants of the C subset lexer: token kinds, the token
// record and the queue entry that carries the tokens caused by one text byte.
// ----------------------------------------------------------------------------
package cslx_pkg;

  localparam int DEF_MAX_TEXT_LEN  = 65536;
  localparam int DEF_MAX_TOKEN_LEN = 255;

  // Entries in the queue between scanner and output stage.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] KIND_NUM    = 4'd0;
  localparam logic [3:0] KIND_IDENT  = 4'd1;
  localparam logic [3:0] KIND_LE     = 4'd2;
  localparam logic [3:0] KIND_GE     = 4'd3;
  localparam logic [3:0] KIND_EQ     = 4'd4;
  localparam logic [3:0] KIND_NE     = 4'd5;
  localparam logic [3:0] KIND_PUNCT  = 4'd6;
  localparam logic [3:0] KIND_IF     = 4'd7;
  localparam logic [3:0] KIND_FOR    = 4'd8;
  localparam logic [3:0] KIND_ELSE   = 4'd9;
  localparam logic [3:0] KIND_WHILE  = 4'd10;
  localparam logic [3:0] KIND_RETURN = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  punct;
    logic [15:0] start;
    logic [7:0]  len;
    logic [30:0] value;
  } token_t;

  // Tokens caused by one byte: a flushed pending token first, then a token
  // from scanning the byte afresh.
  typedef struct packed {
    logic   a_vld;
    token_t a_tok;
    logic   b_vld;
    token_t b_tok;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/cslx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslx_front
// Scanner: takes one text byte per cycle while the queue is not full, keeps
// the lexer state and forms the tokens that the byte completes.
// ----------------------------------------------------------------------------
module cslx_front #(
  parameter int MAX_TEXT_LEN  = cslx_pkg::DEF_MAX_TEXT_LEN,
  parameter int MAX_TOKEN_LEN = cslx_pkg::DEF_MAX_TOKEN_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_byte,
  input  cslx_pkg::q_stat_t q_stat,
  output logic              push,
  output cslx_pkg::pair_t   push_entry
);

  localparam int POS_W = (MAX_TEXT_LEN > 2) ? $clog2(MAX_TEXT_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKEN_LEN);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] PFX_KEEP = CNT_W'(6);
  localparam logic [30:0] NUM_MAX = 31'h7fff_ffff;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OP   = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_WORD = 2'd3;

  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_FOR    = 48'h0000_0066_6f72;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656c_7365;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6c65;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726e;

  logic [1:0]       mode_r, mode_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [30:0]      acc_r, acc_nxt;
  logic [47:0]      pfx_r, pfx_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             halt_r, halt_nxt;

  logic [7:0]        c;
  logic              accept;
  logic              is_letter, is_digit, is_space, is_op, is_punct;
  logic [POS_W+15:0] start_pad, pos_pad;
  logic [CNT_W+7:0]  cnt_pad;
  logic [7:0]        cnt_len;
  logic [CNT_W-1:0]  cnt_bump;
  logic [34:0]       acc_wide;
  logic [30:0]       acc_step;
  logic [3:0]        word_kind;
  logic [3:0]        op_kind;
  cslx_pkg::pair_t   entry;

  assign c        = in_char_byte;
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  assign is_digit  = c >= "0" && c <= "9";
  assign is_space  = c == " " || (c >= 8'd9 && c <= 8'd13);
  assign is_op     = c == "<" || c == ">" || c == "=" || c == "!";
  assign is_punct  = c == "+" || c == "-" || c == "*" || c == "/" || c == "(" ||
                     c == ")" || c == ";" || c == "{" || c == "}";

  assign start_pad = {16'b0, start_r};
  assign pos_pad   = {16'b0, pos_r};
  assign cnt_pad   = {8'b0, cnt_r};
  assign cnt_len   = (cnt_pad > (CNT_W + 8)'(255)) ? 8'd255 : cnt_pad[7:0];
  assign cnt_bump  = (cnt_r < CNT_MAX) ? cnt_r + CNT_ONE : cnt_r;

  // Times ten as two shifted copies, then the new digit.
  assign acc_wide = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + {31'b0, c[3:0]};
  assign acc_step = (acc_wide > {4'b0, NUM_MAX}) ? NUM_MAX : acc_wide[30:0];

  always_comb begin
    word_kind = cslx_pkg::KIND_IDENT;
    if      (cnt_r == CNT_W'(2) && pfx_r == KW_IF)     word_kind = cslx_pkg::KIND_IF;
    else if (cnt_r == CNT_W'(3) && pfx_r == KW_FOR)    word_kind = cslx_pkg::KIND_FOR;
    else if (cnt_r == CNT_W'(4) && pfx_r == KW_ELSE)   word_kind = cslx_pkg::KIND_ELSE;
    else if (cnt_r == CNT_W'(5) && pfx_r == KW_WHILE)  word_kind = cslx_pkg::KIND_WHILE;
    else if (cnt_r == CNT_W'(6) && pfx_r == KW_RETURN) word_kind = cslx_pkg::KIND_RETURN;
  end

  always_comb begin
    unique case (held_r)
      "<":     op_kind = cslx_pkg::KIND_LE;
      ">":     op_kind = cslx_pkg::KIND_GE;
      "=":     op_kind = cslx_pkg::KIND_EQ;
      default: op_kind = cslx_pkg::KIND_NE;
    endcase
  end

  always_comb begin
    logic fresh;
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    pfx_nxt   = pfx_r;
    pos_nxt   = pos_r;
    halt_nxt  = halt_r;
    entry     = '0;
    fresh     = 1'b1;

    // A pending operator, number or word ends here or takes the byte.
    if (halt_r) begin
      fresh = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_OP: begin
          entry.a_vld       = 1'b1;
          entry.a_tok.start = start_pad[15:0];
          entry.a_tok.len   = 8'd1;
          if (c == "=") begin
            entry.a_tok.kind = op_kind;
            entry.a_tok.len  = 8'd2;
            mode_nxt         = MODE_IDLE;
            fresh            = 1'b0;
          end else if (held_r == "!") begin
            entry.a_tok.kind = cslx_pkg::KIND_ERROR;
            halt_nxt         = 1'b1;
            mode_nxt         = MODE_IDLE;
            fresh            = 1'b0;
          end else begin
            entry.a_tok.kind  = cslx_pkg::KIND_PUNCT;
            entry.a_tok.punct = held_r;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            acc_nxt = acc_step;
            cnt_nxt = cnt_bump;
            fresh   = 1'b0;
          end else begin
            entry.a_vld       = 1'b1;
            entry.a_tok.kind  = cslx_pkg::KIND_NUM;
            entry.a_tok.start = start_pad[15:0];
            entry.a_tok.len   = cnt_len;
            entry.a_tok.value = acc_r;
          end
        end
        MODE_WORD: begin
          if (is_letter || is_digit) begin
            if (cnt_r < PFX_KEEP) begin
              pfx_nxt = {pfx_r[39:0], c};
            end
            cnt_nxt = cnt_bump;
            fresh   = 1'b0;
          end else begin
            entry.a_vld       = 1'b1;
            entry.a_tok.kind  = word_kind;
            entry.a_tok.start = start_pad[15:0];
            entry.a_tok.len   = cnt_len;
          end
        end
        MODE_IDLE: begin
        end
      endcase
    end

    // Scan the byte as the start of something new.
    if (fresh) begin
      mode_nxt          = MODE_IDLE;
      entry.b_tok.start = pos_pad[15:0];
      entry.b_tok.len   = 8'd1;
      priority if (c == 8'd0) begin
        entry.b_vld      = 1'b1;
        entry.b_tok.kind = cslx_pkg::KIND_END;
        entry.b_tok.len  = 8'd0;
      end else if (is_space) begin
      end else if (is_op) begin
        mode_nxt  = MODE_OP;
        held_nxt  = c;
        start_nxt = pos_r;
      end else if (is_punct) begin
        entry.b_vld       = 1'b1;
        entry.b_tok.kind  = cslx_pkg::KIND_PUNCT;
        entry.b_tok.punct = c;
      end else if (is_letter) begin
        mode_nxt  = MODE_WORD;
        start_nxt = pos_r;
        cnt_nxt   = CNT_ONE;
        pfx_nxt   = {40'b0, c};
      end else if (is_digit) begin
        mode_nxt  = MODE_NUM;
        start_nxt = pos_r;
        cnt_nxt   = CNT_ONE;
        acc_nxt   = {27'b0, c[3:0]};
      end else begin
        entry.b_vld      = 1'b1;
        entry.b_tok.kind = cslx_pkg::KIND_ERROR;
        halt_nxt         = 1'b1;
      end
    end

    if (c == 8'd0) begin
      pos_nxt  = '0;
      halt_nxt = 1'b0;
      mode_nxt = MODE_IDLE;
    end else if (pos_r < POS_LAST) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign push       = accept && (entry.a_vld || entry.b_vld);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      held_r  <= '0;
      start_r <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      pfx_r   <= '0;
      pos_r   <= '0;
      halt_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      pfx_r   <= pfx_nxt;
      pos_r   <= pos_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

[design/cslx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslx_queue
// Small first-in first-out queue of token pairs between scanner and output.
// ----------------------------------------------------------------------------
module cslx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cslx_pkg::pair_t   push_entry,
  input  logic              pop,
  output cslx_pkg::pair_t   head,
  output cslx_pkg::q_stat_t q_stat
);

  localparam int DEPTH = cslx_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cslx_pkg::pair_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = cnt_r == CNT_FULL;
  assign q_stat.empty = cnt_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/cslx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslx_back
// Output stage: holds one token pair and delivers its tokens one request at
// a time, marking the last token caused by each byte.
// ----------------------------------------------------------------------------
module cslx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cslx_pkg::pair_t   head,
  input  cslx_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_token_kind,
  output logic [7:0]        out_punct_char,
  output logic [15:0]       out_start_pos,
  output logic [7:0]        out_token_len,
  output logic [30:0]       out_num_value,
  output logic              out_last_of_run
);

  cslx_pkg::pair_t  cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic             on_b_r, on_b_nxt;
  cslx_pkg::token_t shown;
  logic             last, take, need_load;

  assign shown     = on_b_r ? cur_r.b_tok : cur_r.a_tok;
  assign last      = on_b_r || !cur_r.b_vld;
  assign out_valid = cur_vld_r;
  assign take      = out_valid && out_ready;
  assign need_load = !cur_vld_r || (take && last);
  assign pop       = need_load && !q_stat.empty;

  assign out_token_kind  = shown.kind;
  assign out_punct_char  = shown.punct;
  assign out_start_pos   = shown.start;
  assign out_token_len   = shown.len;
  assign out_num_value   = shown.value;
  assign out_last_of_run = last;

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    on_b_nxt    = on_b_r;
    if (pop) begin
      cur_nxt     = head;
      cur_vld_nxt = 1'b1;
      on_b_nxt    = !head.a_vld;
    end else if (need_load) begin
      cur_vld_nxt = 1'b0;
    end else if (take) begin
      on_b_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      on_b_r    <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      on_b_r    <= on_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[design/c_subset_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer
// Byte-stream tokenizer for a small C subset, with a scanner front end, a
// token queue and an output stage.
// ----------------------------------------------------------------------------
// The lexer takes one text byte per clock cycle while in_ready is high and
// gives tokens on the out_ channel, one request per token. A byte causes zero,
// one or two tokens; out_last_of_run marks the last token of each byte. The
// scanner updates all lexer state in the cycle the byte is taken, so bytes
// follow back to back with no gap. The output stage delivers one token per
// cycle while out_ready is high, and a four-entry queue of token pairs sits
// between the two, so a stalled output does not stop the scanner until the
// queue fills. A byte's tokens pass through the queue and the output stage's
// pair register before they appear. A byte that yields two tokens (a number,
// word or operator ended by a punctuator, an error or the end of text) needs
// two output requests, so the sustained input rate equals one byte per cycle
// only while the text averages no more than one token per byte. Byte 0 ends
// the text, flushes any pending token and gives an end token; after an error
// token, bytes are dropped up to byte 0, which then gives no end token.
module c_subset_lexer #(
  parameter int MAX_TEXT_LEN  = cslx_pkg::DEF_MAX_TEXT_LEN,
  parameter int MAX_TOKEN_LEN = cslx_pkg::DEF_MAX_TOKEN_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_punct_char,
  output logic [15:0] out_start_pos,
  output logic [7:0]  out_token_len,
  output logic [30:0] out_num_value,
  output logic        out_last_of_run
);

  // Tokens of one byte travel together as a pair; the queue status tells
  // the scanner when to hold off and the output stage when it may load.
  cslx_pkg::pair_t   push_entry;
  cslx_pkg::pair_t   head;
  cslx_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  cslx_front #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_byte(in_char_byte),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  cslx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The output stage holds the pair being delivered in its own register, so
  // out_ payload stays fixed while a request waits.
  cslx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_punct_char (out_punct_char),
    .out_start_pos  (out_start_pos),
    .out_token_len  (out_token_len),
    .out_num_value  (out_num_value),
    .out_last_of_run(out_last_of_run)
  );

endmodule
